FILE: rtl/sli_pkg.sv
// Package for the sorted list block: status codes and the control struct
// that the top level sends to every list cell. No dependencies.
package sli_pkg;

	// Result status codes
	typedef enum logic [2:0] {
		ST_INSERTED  = 3'd0,
		ST_FULL      = 3'd1,
		ST_DELETED   = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_EMPTY     = 3'd4
	} status_t;

	// Operation codes of the mode field
	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_DELETE = 1'b1;

	// Broadcast to the cells: which shift happens at this edge
	typedef struct packed {
		logic do_insert;  // accepted insert, list not full
		logic do_delete;  // accepted delete, value present
	} cell_ctrl_t;

endpackage

FILE: rtl/sorted_list_insert_delete_top.sv
// Top level of the sorted list: a chain of sli_cell instances plus count and
// result registers. Depends on sli_pkg and sli_cell.
//
//  channel  | ports                                          | handshake
//  ---------+------------------------------------------------+-------------------
//  request  | mode, value                                    | start & !busy
//  result   | status, entry_count, is_empty, smallest_value  | done, one cycle
//
// A request is taken in any cycle; all cells compare and shift at the same
// edge, so the rate is one request per clock. The result shows with done in
// the cycle after the request is taken. The depth of the found reduction over
// DEPTH match flags sets the clock path. busy stays low. arst_n clears the
// count and the done strobe; stored entries need no reset. The receiver cannot
// stall, so each result is valid for that single cycle only.
module sorted_list_insert_delete_top #(
	parameter int DEPTH       = 16,
	parameter int VALUE_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               mode,
	input  logic signed [31:0] value,
	output logic               done,
	output logic [2:0]         status,
	output logic [4:0]         entry_count,
	output logic               is_empty,
	output logic signed [31:0] smallest_value
);
	import sli_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] FULL_C = CW'(DEPTH);

	logic [CW-1:0]                 count_q;
	logic                          done_q;
	status_t                       status_q;
	logic signed [VALUE_WIDTH-1:0] val_ext;
	logic signed [VALUE_WIDTH-1:0] entry_w [DEPTH];
	logic signed [VALUE_WIDTH-1:0] right_w [DEPTH];
	logic signed [VALUE_WIDTH-1:0] left_w  [DEPTH];
	logic [DEPTH-1:0]              below_w;
	logic [DEPTH-1:0]              lbelow_w;
	logic [DEPTH-1:0]              match_w;
	logic                          accept;
	logic                          full;
	logic                          empty;
	logic                          found;
	cell_ctrl_t                    ctrl;
	status_t                       status_d;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = (count_q == FULL_C);
	assign empty  = (count_q == '0);
	assign found  = |match_w;

	// Request value to storage width: truncate or sign-extend
	generate
		if (VALUE_WIDTH <= 32) begin : g_in_narrow
			assign val_ext = value[VALUE_WIDTH-1:0];
		end else begin : g_in_wide
			assign val_ext = {{(VALUE_WIDTH-32){value[31]}}, value};
		end
	endgenerate

	// Shift controls broadcast to the chain
	assign ctrl.do_insert = accept && (mode == MODE_INSERT) && !full;
	assign ctrl.do_delete = accept && (mode == MODE_DELETE) && found;

	// Cell chain
	generate
		for (genvar i = 0; i < DEPTH; i++) begin : g_cell
			if (i == 0) begin : g_first
				assign left_w[i]   = val_ext;
				assign lbelow_w[i] = 1'b1;
			end else begin : g_mid
				assign left_w[i]   = entry_w[i-1];
				assign lbelow_w[i] = below_w[i-1];
			end
			if (i == DEPTH - 1) begin : g_last
				assign right_w[i] = entry_w[i];
			end else begin : g_inner
				assign right_w[i] = entry_w[i+1];
			end
			sli_cell #(
				.IDX         (i),
				.VALUE_WIDTH (VALUE_WIDTH),
				.CW          (CW)
			) u_cell (
				.clk         (clk),
				.ctrl        (ctrl),
				.count       (count_q),
				.value       (val_ext),
				.left_entry  (left_w[i]),
				.left_below  (lbelow_w[i]),
				.right_entry (right_w[i]),
				.entry       (entry_w[i]),
				.below       (below_w[i]),
				.match       (match_w[i])
			);
		end
	endgenerate

	// Status of the current request
	always_comb begin
		if (mode == MODE_INSERT) begin
			status_d = full ? ST_FULL : ST_INSERTED;
		end else if (empty) begin
			status_d = ST_EMPTY;
		end else begin
			status_d = found ? ST_DELETED : ST_NOT_FOUND;
		end
	end

	// Count and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (ctrl.do_insert) begin
				count_q <= count_q + CW'(1);
			end else if (ctrl.do_delete) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
		end
	end

	// Result ports; count and head come straight from the updated state
	assign done     = done_q;
	assign status   = status_q;
	assign is_empty = empty;

	generate
		if (CW >= 5) begin : g_cnt_wide
			assign entry_count = count_q[4:0];
		end else begin : g_cnt_narrow
			assign entry_count = {{(5-CW){1'b0}}, count_q};
		end
		if (VALUE_WIDTH >= 32) begin : g_out_wide
			assign smallest_value = empty ? 32'sd0 : entry_w[0][31:0];
		end else begin : g_out_narrow
			assign smallest_value = empty ? 32'sd0 :
				{{(32-VALUE_WIDTH){entry_w[0][VALUE_WIDTH-1]}}, entry_w[0]};
		end
	endgenerate

endmodule

FILE: rtl/sli_cell.sv
// One cell of the sorted list chain: holds one entry, compares it with the
// request value and shifts left or right with its neighbors. Uses sli_pkg.
module sli_cell #(
	parameter int IDX         = 0,
	parameter int VALUE_WIDTH = 32,
	parameter int CW          = 5
) (
	input  logic                          clk,
	input  sli_pkg::cell_ctrl_t           ctrl,
	input  logic [CW-1:0]                 count,
	input  logic signed [VALUE_WIDTH-1:0] value,
	input  logic signed [VALUE_WIDTH-1:0] left_entry,
	input  logic                          left_below,
	input  logic signed [VALUE_WIDTH-1:0] right_entry,
	output logic signed [VALUE_WIDTH-1:0] entry,
	output logic                          below,
	output logic                          match
);
	import sli_pkg::*;

	localparam logic [CW-1:0] IDX_C = CW'(IDX);

	logic signed [VALUE_WIDTH-1:0] entry_q;
	logic                          occupied;

	// Local compares; the list is ascending so "below" is a prefix of the chain
	assign occupied = (IDX_C < count);
	assign below    = occupied && (entry_q < value);
	assign match    = occupied && (entry_q == value);
	assign entry    = entry_q;

	// Insert: keep if below, take the new value at the boundary, else shift right.
	// Delete: cells at or past the first match take the right neighbor.
	always_ff @(posedge clk) begin
		if (ctrl.do_insert) begin
			if (!below) begin
				entry_q <= left_below ? value : left_entry;
			end
		end else if (ctrl.do_delete) begin
			if (!below) begin
				entry_q <= right_entry;
			end
		end
	end

endmodule

FILE: tb/sorted_list_insert_delete_top_test.sv
`timescale 1ns / 1ps
// Self-checking test of sorted_list_insert_delete_top: directed table plus random
// insert/delete traffic, checked against an ordered-queue model. Needs sli_pkg.

module sorted_list_insert_delete_top_test;
	import sli_pkg::*;

	localparam int LIST_DEPTH   = 16;
	localparam int RAND_PER_PH  = 667;
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 4;

	typedef struct {
		status_t            st;
		logic [4:0]         cnt;
		logic               emp;
		logic signed [31:0] head;
	} list_result_t;

	typedef struct {
		logic               m;
		logic signed [31:0] v;
		bit                 typed;
		list_result_t       res;
	} stim_row_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               mode;
	logic signed [31:0] value;
	logic               done;
	logic [2:0]         status;
	logic [4:0]         entry_count;
	logic               is_empty;
	logic signed [31:0] smallest_value;

	logic signed [31:0] sorted_vals[$];
	list_result_t       pending_results[$];
	stim_row_t          dir_rows[$];
	int                 err_cnt;
	int                 stall_cnt;

	sorted_list_insert_delete_top #(
		.DEPTH(LIST_DEPTH),
		.VALUE_WIDTH(32)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.value(value),
		.done(done),
		.status(status),
		.entry_count(entry_count),
		.is_empty(is_empty),
		.smallest_value(smallest_value)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Ordered list model: insert before first entry not smaller, delete first equal
	function automatic list_result_t apply_request(logic m, logic signed [31:0] v);
		list_result_t r;
		int pos;
		pos = 0;
		if (m == MODE_INSERT) begin
			if (sorted_vals.size() >= LIST_DEPTH) begin
				r.st = ST_FULL;
			end else begin
				while (pos < sorted_vals.size() && v > sorted_vals[pos])
					pos++;
				sorted_vals.insert(pos, v);
				r.st = ST_INSERTED;
			end
		end else if (sorted_vals.size() == 0) begin
			r.st = ST_EMPTY;
		end else begin
			while (pos < sorted_vals.size() && sorted_vals[pos] != v)
				pos++;
			if (pos == sorted_vals.size()) begin
				r.st = ST_NOT_FOUND;
			end else begin
				sorted_vals.delete(pos);
				r.st = ST_DELETED;
			end
		end
		r.cnt  = 5'(sorted_vals.size());
		r.emp  = (sorted_vals.size() == 0);
		r.head = (sorted_vals.size() == 0) ? 32'sd0 : sorted_vals[0];
		return r;
	endfunction

	function automatic void add_row(logic m, logic signed [31:0] v, bit typed = 1'b0,
			status_t st = ST_INSERTED, int cnt = 0, logic emp = 1'b0,
			logic signed [31:0] head = 32'sd0);
		stim_row_t row;
		row.m         = m;
		row.v         = v;
		row.typed     = typed;
		row.res.st    = st;
		row.res.cnt   = 5'(cnt);
		row.res.emp   = emp;
		row.res.head  = head;
		dir_rows.push_back(row);
	endfunction

	// Four in ten picks are values already stored, so deletes hit and duplicates form
	function automatic logic signed [31:0] pick_value();
		logic signed [31:0] v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				if (sorted_vals.size() > 0)
					v = sorted_vals[$urandom_range(0, sorted_vals.size() - 1)];
				else
					v = $urandom();
			end
			4, 5: begin
				v = $signed($urandom_range(0, 16)) - 32'sd8;
			end
			6: begin
				case ($urandom_range(0, 3))
					0: v = 32'sh80000000;
					1: v = 32'sh7FFFFFFF;
					2: v = 32'sd0;
					default: v = -32'sd1;
				endcase
			end
			default: begin
				v = $urandom();
			end
		endcase
		return v;
	endfunction

	// Drive one request at the falling edge, hold until taken, record expectation
	task automatic send_request(logic m, logic signed [31:0] v, int idle_pct,
			bit typed, list_result_t typed_res);
		list_result_t pred;
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		mode  <= m;
		value <= v;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pred = apply_request(m, v);
		pending_results.push_back(typed ? typed_res : pred);
		@(negedge clk);
	endtask

	// Result checker
	always @(posedge clk) begin
		list_result_t e;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result status %0d count %0d", $time, status,
					entry_count);
				err_cnt++;
			end else begin
				e = pending_results.pop_front();
				if (status !== e.st) begin
					$display("%0t: status expected %0d, got %0d", $time, e.st, status);
					err_cnt++;
				end
				if (entry_count !== e.cnt) begin
					$display("%0t: entry_count expected %0d, got %0d", $time, e.cnt,
						entry_count);
					err_cnt++;
				end
				if (is_empty !== e.emp) begin
					$display("%0t: is_empty expected %0b, got %0b", $time, e.emp, is_empty);
					err_cnt++;
				end
				if (smallest_value !== e.head) begin
					$display("%0t: smallest_value expected %0d, got %0d", $time, e.head,
						smallest_value);
					err_cnt++;
				end
			end
		end
	end

	// Watchdog on cycles with no request taken and no result
	always @(posedge clk) begin
		if ((arst_n && start && !busy) || done || !arst_n) begin
			stall_cnt <= 0;
		end else if (stall_cnt >= STALL_LIMIT) begin
			$display("sorted_list_insert_delete_top_test: done, errors");
			$finish;
		end else begin
			stall_cnt <= stall_cnt + 1;
		end
	end

	initial begin
		list_result_t no_res;
		int ins_pct;
		int idle_pct;
		err_cnt    = 0;
		stall_cnt  = 0;
		arst_n     = 1'b0;
		start      = 1'b0;
		mode       = MODE_INSERT;
		value      = 32'sd0;
		no_res.st  = ST_INSERTED;
		no_res.cnt = 5'd0;
		no_res.emp = 1'b0;
		no_res.head = 32'sd0;

		// Directed table: empty delete, extremes, duplicates, full, absent value
		add_row(MODE_DELETE, 32'sd5, 1'b1, ST_EMPTY, 0, 1'b1, 32'sd0);
		add_row(MODE_INSERT, 32'sd0, 1'b1, ST_INSERTED, 1, 1'b0, 32'sd0);
		add_row(MODE_INSERT, 32'sh7FFFFFFF, 1'b1, ST_INSERTED, 2, 1'b0, 32'sd0);
		add_row(MODE_INSERT, 32'sh80000000, 1'b1, ST_INSERTED, 3, 1'b0, 32'sh80000000);
		add_row(MODE_INSERT, 32'sd0);
		add_row(MODE_INSERT, -32'sd1);
		add_row(MODE_INSERT, 32'sd1);
		add_row(MODE_INSERT, 32'sd100);
		add_row(MODE_INSERT, -32'sd100);
		add_row(MODE_INSERT, 32'sd7);
		add_row(MODE_INSERT, 32'sd7);
		add_row(MODE_INSERT, 32'sh40000000);
		add_row(MODE_INSERT, 32'shC0000000);
		add_row(MODE_INSERT, 32'sd2);
		add_row(MODE_INSERT, 32'sd3);
		add_row(MODE_INSERT, -32'sd2);
		add_row(MODE_INSERT, 32'sd55);
		add_row(MODE_INSERT, 32'sd42, 1'b1, ST_FULL, 16, 1'b0, 32'sh80000000);
		add_row(MODE_DELETE, 32'sd12345, 1'b1, ST_NOT_FOUND, 16, 1'b0, 32'sh80000000);
		add_row(MODE_DELETE, 32'sd0);
		add_row(MODE_DELETE, 32'sh80000000);
		add_row(MODE_DELETE, 32'sd7);
		add_row(MODE_DELETE, 32'sh7FFFFFFF);
		add_row(MODE_DELETE, 32'sd0);
		add_row(MODE_DELETE, 32'sd0);

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i])
			send_request(dir_rows[i].m, dir_rows[i].v, 0, dir_rows[i].typed,
				dir_rows[i].res);

		// Random traffic: sender idles rarely, then often, then never
		ins_pct = 50;
		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = (ph == 0) ? 11 : (ph == 1) ? 86 : 0;
			for (int n = 0; n < RAND_PER_PH; n++) begin
				// Runs with a fill, drain or no bias so the list sweeps empty to full
				if (n % 32 == 0) begin
					case ($urandom_range(0, 2))
						0: ins_pct = 25;
						1: ins_pct = 50;
						default: ins_pct = 80;
					endcase
				end
				send_request(($urandom_range(0, 99) < ins_pct) ? MODE_INSERT : MODE_DELETE,
					pick_value(), idle_pct, 1'b0, no_res);
			end
		end
		start <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (err_cnt == 0)
			$display("sorted_list_insert_delete_top_test: done, clean");
		else
			$display("sorted_list_insert_delete_top_test: done, errors");
		$finish;
	end

endmodule
